/* hw/rtl/rrb_pkg.sv */
// ----------------------------------------------------------------------------
// rrb_pkg
// Shared widths, codes and payload types of the reorder receive buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package rrb_pkg;

  localparam int SEQ_W         = 32;
  localparam int OFF_W         = 11;
  localparam int BYTE_W        = 8;
  localparam int SEGMENT_BYTES = 1400;

  // slot index reduction: digits of the byte position per pipeline stage
  localparam int MOD_DIGIT  = 4;
  localparam int MOD_STAGES = SEQ_W / MOD_DIGIT;

  localparam int OUT_DEPTH = 8;
  localparam int OUT_AW    = 3;

  localparam logic [1:0] MODE_DATA = 2'd0;
  localparam logic [1:0] MODE_FIN  = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;

  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_ACK    = 2'd1;
  localparam logic [1:0] KIND_FINACK = 2'd2;
  localparam logic [1:0] KIND_BUSY   = 2'd3;

  typedef enum logic [1:0] {
    CLASS_NONE    = 2'd0,
    CLASS_INORDER = 2'd1,
    CLASS_AHEAD   = 2'd2,
    CLASS_BEHIND  = 2'd3
  } class_t;

  typedef enum logic [2:0] {
    ACT_NONE       = 3'd0,
    ACT_FIN        = 3'd1,
    ACT_BUSY       = 3'd2,
    ACT_INORD_BYTE = 3'd3,
    ACT_INORD_LAST = 3'd4,
    ACT_AHEAD_ACK  = 3'd5,
    ACT_TICK       = 3'd6
  } act_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [SEQ_W-1:0]  seg_seq;
    logic [OFF_W-1:0]  byte_offset;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } seg_t;

  typedef struct packed {
    logic [1:0]        out_kind;
    logic [BYTE_W-1:0] out_byte;
    logic [SEQ_W-1:0]  ack_number;
    logic              run_end;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t res;
  } res_slot_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } store_word_t;

endpackage

`default_nettype wire

/* hw/rtl/rrb_ifs.sv */
// ----------------------------------------------------------------------------
// rrb_seg_if / rrb_res_if
// Valid/ready channels for incoming segment bytes and outgoing results.
// ----------------------------------------------------------------------------
`default_nettype none

interface rrb_seg_if import rrb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [SEQ_W-1:0]  seg_seq;
  logic [OFF_W-1:0]  byte_offset;
  logic [BYTE_W-1:0] data_byte;
  logic              last_byte;

  modport source (output valid, mode, seg_seq, byte_offset, data_byte, last_byte,
                  input ready);
  modport sink (input valid, mode, seg_seq, byte_offset, data_byte, last_byte,
                output ready);
endinterface

interface rrb_res_if import rrb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        out_kind;
  logic [BYTE_W-1:0] out_byte;
  logic [SEQ_W-1:0]  ack_number;
  logic              run_end;

  modport source (output valid, out_kind, out_byte, ack_number, run_end, input ready);
  modport sink (input valid, out_kind, out_byte, ack_number, run_end, output ready);
endinterface

`default_nettype wire

/* hw/rtl/rrb_slot_pipe.sv */
// ----------------------------------------------------------------------------
// rrb_slot_pipe
// Computes the ring slot (seg_seq + byte_offset) mod STORE_DEPTH, one digit
// of the byte position per stage, with a shared stall.
// ----------------------------------------------------------------------------
`default_nettype none

module rrb_slot_pipe import rrb_pkg::*; #(
  parameter int  STORE_DEPTH = 4096,
  localparam int AW          = $clog2(STORE_DEPTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             in_valid,
  input  seg_t             in_seg,
  output logic             out_valid,
  output seg_t             out_seg,
  output logic [SEQ_W-1:0] out_pos,
  output logic [AW-1:0]    out_slot
);

  localparam logic [AW:0] DEPTH_CMP = (AW + 1)'(STORE_DEPTH);

  logic             v      [MOD_STAGES+1];
  seg_t             seg_q  [MOD_STAGES+1];
  logic [SEQ_W-1:0] pos_q  [MOD_STAGES+1];
  logic [AW-1:0]    rem_q  [1:MOD_STAGES];

  function automatic logic [AW-1:0] mod_step(input logic [AW-1:0]        rem,
                                             input logic [MOD_DIGIT-1:0] dig);
    logic [AW:0] acc;
    acc = {1'b0, rem};
    for (int i = MOD_DIGIT - 1; i >= 0; i--) begin
      acc = {acc[AW-1:0], dig[i]};
      if (acc >= DEPTH_CMP) begin
        acc = acc - DEPTH_CMP;
      end
    end
    return acc[AW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= MOD_STAGES; k++) begin
        v[k] <= 1'b0;
      end
    end else if (advance) begin
      v[0] <= in_valid;
      for (int k = 1; k <= MOD_STAGES; k++) begin
        v[k] <= v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      seg_q[0] <= in_seg;
      pos_q[0] <= in_seg.seg_seq + SEQ_W'(in_seg.byte_offset);
      for (int k = 1; k <= MOD_STAGES; k++) begin
        seg_q[k] <= seg_q[k-1];
        pos_q[k] <= pos_q[k-1];
      end
      rem_q[1] <= mod_step('0, pos_q[0][SEQ_W-1 -: MOD_DIGIT]);
      for (int k = 2; k <= MOD_STAGES; k++) begin
        rem_q[k] <= mod_step(rem_q[k-1], pos_q[k-1][SEQ_W-1-MOD_DIGIT*(k-1) -: MOD_DIGIT]);
      end
    end
  end

  assign out_valid = v[MOD_STAGES];
  assign out_seg   = seg_q[MOD_STAGES];
  assign out_pos   = pos_q[MOD_STAGES];
  assign out_slot  = rem_q[MOD_STAGES];

endmodule

`default_nettype wire

/* hw/rtl/rrb_store.sv */
// ----------------------------------------------------------------------------
// rrb_store
// Ring store of bytes with valid marks. One registered read and, outside the
// clearing pass after reset that zeroes every valid mark, one write per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rrb_store import rrb_pkg::*; #(
  parameter int  STORE_DEPTH = 4096,
  localparam int AW          = $clog2(STORE_DEPTH)
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [AW-1:0] wr_addr,
  input  store_word_t wr_word,
  input  logic [AW-1:0] rd_addr,
  output store_word_t rd_word,
  output logic        clearing
);

  localparam logic [AW-1:0] LAST_SLOT = AW'(STORE_DEPTH - 1);

  store_word_t   mem [STORE_DEPTH];
  logic [AW-1:0] clr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      if (clr_idx == LAST_SLOT) begin
        clearing <= 1'b0;
      end
      clr_idx <= clr_idx + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_idx] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
    rd_word <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* hw/rtl/rrb_out_fifo.sv */
// ----------------------------------------------------------------------------
// rrb_out_fifo
// Result queue: takes up to two results a cycle, presents one a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rrb_out_fifo import rrb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  res_slot_t         first,
  input  res_slot_t         second,
  output logic [OUT_AW:0]   count,
  rrb_res_if.source         result
);

  res_t              q [OUT_DEPTH];
  logic [OUT_AW-1:0] wp;
  logic [OUT_AW-1:0] rp;
  logic [1:0]        n_push;
  logic              pop;

  assign n_push = {1'b0, first.valid} + {1'b0, second.valid};
  assign pop    = result.valid && result.ready;

  always_ff @(posedge clk) begin
    if (first.valid) begin
      q[wp] <= first.res;
    end
    if (second.valid) begin
      q[wp + OUT_AW'(1)] <= second.res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + OUT_AW'(n_push);
      rp    <= rp + OUT_AW'(pop);
      count <= count + (OUT_AW + 1)'(n_push) - (OUT_AW + 1)'(pop);
    end
  end

  assign result.valid      = (count != '0);
  assign result.out_kind   = q[rp].out_kind;
  assign result.out_byte   = q[rp].out_byte;
  assign result.ack_number = q[rp].ack_number;
  assign result.run_end    = q[rp].run_end;

endmodule

`default_nettype wire

/* hw/rtl/reorder_receive_buffer.sv */
// ----------------------------------------------------------------------------
// reorder_receive_buffer
// Receive-side segment reassembly with a ring store, valid marks, drain on
// demand and cumulative ack.
// ----------------------------------------------------------------------------
// Channel  Side    Payload                                           Handshake
// segment  sink    mode, seg_seq, byte_offset, data_byte, last_byte  valid/ready
// result   source  out_kind, out_byte, ack_number, run_end           valid/ready
//
// One request per cycle while results drain and each yields at most one
// result; requests that yield a byte and an ack are limited by the
// one-result-per-cycle queue. A request passes 9 slot stages, the store read
// and the queue. After reset a clearing pass zeroes the valid marks, segment
// ready low meanwhile. A stalled result side backs up into segment ready
// once the queue cannot take two more results per request in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module reorder_receive_buffer import rrb_pkg::*; #(
  parameter int STORE_DEPTH = 4096
) (
  input  logic      clk,
  input  logic      rst,
  rrb_seg_if.sink   segment,
  rrb_res_if.source result
);

  localparam int            AW        = $clog2(STORE_DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(STORE_DEPTH - 1);

  // slot pipeline
  seg_t             seg_in;
  logic             advance;
  logic             p_valid;
  seg_t             p_seg;
  logic [SEQ_W-1:0] p_pos;
  logic [AW-1:0]    p_slot;

  // store
  logic          clearing;
  logic          wr_en;
  logic          wr_en_a;
  logic [AW-1:0] wr_addr;
  store_word_t   wr_word;
  logic [AW-1:0] rd_addr;
  store_word_t   rd_word;

  // state
  logic [SEQ_W-1:0]  expected;
  logic [AW-1:0]     exp_slot;
  class_t            segment_class;
  logic              draining;
  logic              draining_next;
  logic              closed;
  logic [BYTE_W-1:0] head;

  // request stage
  logic              a_go;
  logic              room;
  act_t              act;
  class_t            cls;
  class_t            class_a;
  logic [SEQ_W-1:0]  expected_a;
  logic [AW-1:0]     exp_slot_a;
  logic              closed_a;
  logic [BYTE_W-1:0] a_byte;
  logic [SEQ_W-1:0]  a_ack;
  logic              drain_eff;
  logic [BYTE_W-1:0] head_eff;
  logic [AW-1:0]     in_nxt;
  logic [AW-1:0]     tick_nxt;

  // result stage
  logic              b_valid;
  act_t              b_act;
  logic [BYTE_W-1:0] b_byte;
  logic [SEQ_W-1:0]  b_ack;
  logic              b_rd;
  res_t              r_byte;
  res_t              r_ack;
  res_t              r_ctl;
  res_slot_t         first;
  res_slot_t         second;
  logic [OUT_AW:0]   fifo_count;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0]    slot,
                                              input logic [SEQ_W-1:0] seq);
    logic [AW-1:0] nxt;
    if (seq == '1 || slot == LAST_SLOT) begin
      nxt = '0;
    end else begin
      nxt = slot + AW'(1);
    end
    return nxt;
  endfunction

  assign seg_in = '{mode:        segment.mode,
                    seg_seq:     segment.seg_seq,
                    byte_offset: segment.byte_offset,
                    data_byte:   segment.data_byte,
                    last_byte:   segment.last_byte};

  assign advance       = !p_valid || a_go;
  assign segment.ready = advance && !clearing;

  rrb_slot_pipe #(.STORE_DEPTH(STORE_DEPTH)) u_slot_pipe (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .in_valid (segment.valid && segment.ready),
    .in_seg   (seg_in),
    .out_valid(p_valid),
    .out_seg  (p_seg),
    .out_pos  (p_pos),
    .out_slot (p_slot)
  );

  rrb_store #(.STORE_DEPTH(STORE_DEPTH)) u_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_word (wr_word),
    .rd_addr (rd_addr),
    .rd_word (rd_word),
    .clearing(clearing)
  );

  // room for the results of the request in flight and of this one
  assign room = ({1'b0, fifo_count} + (b_valid ? (OUT_AW + 2)'(2) : '0))
                <= (OUT_AW + 2)'(OUT_DEPTH - 2);
  assign a_go = p_valid && room;

  // read data of the previous request is forwarded
  assign b_rd      = b_valid && (b_act == ACT_INORD_LAST || b_act == ACT_TICK);
  assign drain_eff = b_rd ? rd_word.valid : draining;
  assign head_eff  = b_rd ? rd_word.data : head;
  assign in_nxt    = next_slot(p_slot, p_pos);
  assign tick_nxt  = next_slot(exp_slot, expected);

  always_comb begin
    act        = ACT_NONE;
    cls        = segment_class;
    class_a    = segment_class;
    expected_a = expected;
    exp_slot_a = exp_slot;
    closed_a   = closed;
    a_byte     = p_seg.data_byte;
    a_ack      = expected;
    wr_en_a    = 1'b0;
    wr_addr    = p_slot;
    wr_word    = '{valid: 1'b0, data: p_seg.data_byte};
    rd_addr    = exp_slot;
    if (!closed) begin
      case (p_seg.mode)
        MODE_FIN: begin
          act      = ACT_FIN;
          closed_a = 1'b1;
        end
        MODE_TICK: begin
          if (drain_eff) begin
            act        = ACT_TICK;
            wr_en_a    = 1'b1;
            wr_addr    = exp_slot;
            wr_word    = '{valid: 1'b0, data: head_eff};
            rd_addr    = tick_nxt;
            a_byte     = head_eff;
            expected_a = expected + SEQ_W'(1);
            exp_slot_a = tick_nxt;
            a_ack      = expected + SEQ_W'(1);
          end
        end
        MODE_DATA: begin
          if (SEQ_W'(p_seg.byte_offset) < SEQ_W'(SEGMENT_BYTES)) begin
            if (drain_eff) begin
              act = ACT_BUSY;
            end else begin
              if (p_seg.byte_offset == '0) begin
                if (p_seg.seg_seq == expected) begin
                  cls = CLASS_INORDER;
                end else if (p_seg.seg_seq > expected) begin
                  cls = CLASS_AHEAD;
                end else begin
                  cls = CLASS_BEHIND;
                end
              end
              class_a = p_seg.last_byte ? CLASS_NONE : cls;
              case (cls)
                CLASS_INORDER: begin
                  wr_en_a = 1'b1;
                  if (p_seg.last_byte) begin
                    act        = ACT_INORD_LAST;
                    rd_addr    = in_nxt;
                    expected_a = p_pos + SEQ_W'(1);
                    exp_slot_a = in_nxt;
                    a_ack      = p_pos + SEQ_W'(1);
                  end else begin
                    act = ACT_INORD_BYTE;
                  end
                end
                CLASS_AHEAD: begin
                  wr_en_a       = 1'b1;
                  wr_word.valid = 1'b1;
                  if (p_seg.last_byte) begin
                    act = ACT_AHEAD_ACK;
                  end
                end
                default: begin
                end
              endcase
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign wr_en = a_go && wr_en_a;

  always_comb begin
    draining_next = draining;
    if (b_rd) begin
      draining_next = rd_word.valid;
    end
    if (a_go && act == ACT_FIN) begin
      draining_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected      <= '0;
      exp_slot      <= '0;
      segment_class <= CLASS_NONE;
      closed        <= 1'b0;
      draining      <= 1'b0;
      b_valid       <= 1'b0;
    end else begin
      if (a_go) begin
        expected      <= expected_a;
        exp_slot      <= exp_slot_a;
        segment_class <= class_a;
        closed        <= closed_a;
      end
      draining <= draining_next;
      b_valid  <= a_go && (act != ACT_NONE);
    end
  end

  always_ff @(posedge clk) begin
    if (a_go) begin
      b_act  <= act;
      b_byte <= a_byte;
      b_ack  <= a_ack;
    end
    if (b_rd) begin
      head <= rd_word.data;
    end
  end

  always_comb begin
    r_byte = '{out_kind: KIND_BYTE, out_byte: b_byte, ack_number: '0, run_end: 1'b1};
    r_ack  = '{out_kind: KIND_ACK, out_byte: '0, ack_number: b_ack, run_end: 1'b1};
    r_ctl  = '{out_kind: KIND_FINACK, out_byte: '0, ack_number: '0, run_end: 1'b1};
    first  = '0;
    second = '0;
    if (b_valid) begin
      case (b_act)
        ACT_FIN: begin
          first = '{valid: 1'b1, res: r_ctl};
        end
        ACT_BUSY: begin
          r_ctl.out_kind = KIND_BUSY;
          first          = '{valid: 1'b1, res: r_ctl};
        end
        ACT_INORD_BYTE: begin
          first = '{valid: 1'b1, res: r_byte};
        end
        ACT_AHEAD_ACK: begin
          first = '{valid: 1'b1, res: r_ack};
        end
        ACT_INORD_LAST, ACT_TICK: begin
          r_byte.run_end = rd_word.valid;
          first          = '{valid: 1'b1, res: r_byte};
          second         = '{valid: !rd_word.valid, res: r_ack};
        end
        default: begin
        end
      endcase
    end
  end

  rrb_out_fifo u_out_fifo (
    .clk   (clk),
    .rst   (rst),
    .first (first),
    .second(second),
    .count (fifo_count),
    .result(result)
  );

endmodule

`default_nettype wire

/* hw/rtl/rrb_checker.sv */
// ----------------------------------------------------------------------------
// rrb_checker
// Port-level checks of the reorder receive buffer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rrb_checker import rrb_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              seg_ready,
  input logic              res_valid,
  input logic              res_ready,
  input logic [1:0]        res_kind,
  input logic [BYTE_W-1:0] res_byte,
  input logic [SEQ_W-1:0]  res_ack,
  input logic              res_end
);

  // segment ready is low right after reset, as the clearing pass begins
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !seg_ready)
    else $error("segment ready during clearing pass");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=>
      res_valid && $stable({res_kind, res_byte, res_ack, res_end}))
    else $error("stalled result changed");

  // ack, finack and busy always close the run of their request
  a_ctrl_closes_run: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_kind != KIND_BYTE |-> res_end && res_byte == '0)
    else $error("control result not last or carries a byte");

  a_byte_no_ack: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_kind == KIND_BYTE |-> res_ack == '0)
    else $error("byte result carries an ack number");

endmodule

bind reorder_receive_buffer rrb_checker u_rrb_checker (
  .clk      (clk),
  .rst      (rst),
  .seg_ready(segment.ready),
  .res_valid(result.valid),
  .res_ready(result.ready),
  .res_kind (result.out_kind),
  .res_byte (result.out_byte),
  .res_ack  (result.ack_number),
  .res_end  (result.run_end)
);

`default_nettype wire

/* tb/rrb_reassembly_check.sv */
// ----------------------------------------------------------------------------
// rrb_reassembly_check
// Watches the segment and result channels of the reorder receive buffer.
// Every accepted request runs through a cycle-free model of the reassembly
// (classification, ring store with valid marks, drain, acks, fin). The
// model queues the results it predicts. Every accepted result is compared
// with the oldest queued prediction. Mismatches and unexpected results are
// counted for the top.
// ----------------------------------------------------------------------------
module rrb_reassembly_check import rrb_pkg::*; #(
  parameter int unsigned STORE_DEPTH = 4096
) (
  input  logic              clk,
  input  logic              rst,
  rrb_seg_if                seg,
  rrb_res_if                res,
  output int unsigned       fail_count,
  output int unsigned       pending_count,
  output logic [SEQ_W-1:0]  next_expected,
  output logic              draining_now
);

  logic [SEQ_W-1:0]  exp_seq;
  class_t            seg_class;
  logic [BYTE_W-1:0] stored [STORE_DEPTH];
  bit [STORE_DEPTH-1:0] marked;
  bit                draining;
  bit                closed;
  res_t              due_results [$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
    next_expected = '0;
    draining_now  = 1'b0;
  end

  function automatic res_t result_of(input logic [1:0] kind, input logic [BYTE_W-1:0] b,
                                     input logic [SEQ_W-1:0] ack);
    result_of = '{out_kind: kind, out_byte: b, ack_number: ack, run_end: 1'b0};
  endfunction

  task automatic reassemble(input seg_t req);
    res_t             outs [2];
    int               n;
    int unsigned      slot;
    logic [SEQ_W-1:0] pos;
    class_t           cls;
    n = 0;
    if (!closed) begin
      case (req.mode)
        MODE_FIN: begin
          outs[n] = result_of(KIND_FINACK, '0, '0);
          n++;
          closed   = 1'b1;
          draining = 1'b0;
        end
        MODE_TICK: begin
          if (draining) begin
            slot = exp_seq % STORE_DEPTH;
            if (marked[slot]) begin
              marked[slot] = 1'b0;
              outs[n] = result_of(KIND_BYTE, stored[slot], '0);
              n++;
              exp_seq++;
            end
            if (!marked[exp_seq % STORE_DEPTH]) begin
              draining = 1'b0;
              outs[n] = result_of(KIND_ACK, '0, exp_seq);
              n++;
            end
          end
        end
        MODE_DATA: begin
          if (req.byte_offset < SEGMENT_BYTES) begin
            if (draining) begin
              outs[n] = result_of(KIND_BUSY, '0, '0);
              n++;
            end else begin
              if (req.byte_offset == '0) begin
                if (req.seg_seq == exp_seq) seg_class = CLASS_INORDER;
                else if (req.seg_seq > exp_seq) seg_class = CLASS_AHEAD;
                else seg_class = CLASS_BEHIND;
              end
              pos  = req.seg_seq + SEQ_W'(req.byte_offset);
              slot = pos % STORE_DEPTH;
              cls  = seg_class;
              if (req.last_byte) seg_class = CLASS_NONE;
              case (cls)
                CLASS_INORDER: begin
                  stored[slot] = req.data_byte;
                  marked[slot] = 1'b0;
                  outs[n] = result_of(KIND_BYTE, req.data_byte, '0);
                  n++;
                  if (req.last_byte) begin
                    exp_seq = pos + 1'b1;
                    if (marked[exp_seq % STORE_DEPTH]) begin
                      draining = 1'b1;
                    end else begin
                      outs[n] = result_of(KIND_ACK, '0, exp_seq);
                      n++;
                    end
                  end
                end
                CLASS_AHEAD: begin
                  stored[slot] = req.data_byte;
                  marked[slot] = 1'b1;
                  if (req.last_byte) begin
                    outs[n] = result_of(KIND_ACK, '0, exp_seq);
                    n++;
                  end
                end
                default: ;
              endcase
            end
          end
        end
        default: ;
      endcase
    end
    if (n > 0) outs[n-1].run_end = 1'b1;
    for (int i = 0; i < n; i++) due_results.push_back(outs[i]);
  endtask

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst) begin
      exp_seq   = '0;
      seg_class = CLASS_NONE;
      marked    = '0;
      draining  = 1'b0;
      closed    = 1'b0;
      due_results.delete();
    end else begin
      // results first: a result never belongs to a request of the same edge
      if (res.valid && res.ready) begin
        got = {res.out_kind, res.out_byte, res.ack_number, res.run_end};
        if (due_results.size() == 0) begin
          if (fail_count < 40)
            $display("%0t: unexpected result kind %0d byte %02h ack %08h end %0d",
                     $time, got.out_kind, got.out_byte, got.ack_number, got.run_end);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          if (got.out_kind !== want.out_kind || got.out_byte !== want.out_byte ||
              got.ack_number !== want.ack_number || got.run_end !== want.run_end) begin
            if (fail_count < 40)
              $display("%0t: expected kind %0d byte %02h ack %08h end %0d, got kind %0d byte %02h ack %08h end %0d",
                       $time, want.out_kind, want.out_byte, want.ack_number, want.run_end,
                       got.out_kind, got.out_byte, got.ack_number, got.run_end);
            fail_count++;
          end
        end
      end
      if (seg.valid && seg.ready)
        reassemble({seg.mode, seg.seg_seq, seg.byte_offset, seg.data_byte, seg.last_byte});
    end
    pending_count = due_results.size();
    next_expected = exp_seq;
    draining_now  = draining;
  end

endmodule

/* tb/reorder_receive_buffer_tb.sv */
// ----------------------------------------------------------------------------
// reorder_receive_buffer_tb
// Stimulus and verdict for the reorder receive buffer. A directed opening
// covers ignored items, unclassified bytes, ahead, in-order, behind, drain
// and busy cases, and store wrap. Random rounds follow: windows of segments
// sent in order, reversed or shuffled, with duplicates, broken segments
// and noise. They run under four idling phases and one long result
// hold-off. A fin with a drain in progress closes the run.
// ----------------------------------------------------------------------------
module reorder_receive_buffer_tb;
  import rrb_pkg::*;

  localparam int unsigned STORE_DEPTH  = 4096;
  localparam int unsigned PHASE_ITEMS  = 500;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam logic [1:0]  MODE_UNUSED  = 2'd3;

  logic clk = 1'b0;
  logic rst;

  rrb_seg_if seg_ch ();
  rrb_res_if res_ch ();

  int unsigned       fail_count;
  int unsigned       pending_count;
  logic [SEQ_W-1:0]  next_expected;
  logic              draining_now;

  int unsigned phase;
  int unsigned counted_items;
  bit          hold_go;
  bit          held;
  int unsigned hold_left;

  reorder_receive_buffer #(.STORE_DEPTH(STORE_DEPTH)) dut (
    .clk     (clk),
    .rst     (rst),
    .segment (seg_ch),
    .result  (res_ch)
  );

  rrb_reassembly_check #(.STORE_DEPTH(STORE_DEPTH)) check (
    .clk           (clk),
    .rst           (rst),
    .seg           (seg_ch),
    .res           (res_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .next_expected (next_expected),
    .draining_now  (draining_now)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // result side: random stalls in phases 2 and 3, one long hold-off
  initial begin
    res_ch.ready = 1'b0;
    held      = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_go && !held) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= (phase == 2 ? 66 : phase == 3 ? 10 : 0));
      end
    end
  end

  task automatic send(input logic [1:0] mode, input logic [SEQ_W-1:0] seq,
                      input logic [OFF_W-1:0] off, input logic [BYTE_W-1:0] data,
                      input logic last);
    while ($urandom_range(99) < (phase == 1 ? 66 : phase == 3 ? 10 : 0)) begin
      seg_ch.valid <= 1'b0;
      @(negedge clk);
    end
    if ((mode == MODE_DATA && off < SEGMENT_BYTES) || (mode == MODE_TICK && draining_now))
      counted_items++;
    seg_ch.valid       <= 1'b1;
    seg_ch.mode        <= mode;
    seg_ch.seg_seq     <= seq;
    seg_ch.byte_offset <= off;
    seg_ch.data_byte   <= data;
    seg_ch.last_byte   <= last;
    do @(posedge clk); while (!seg_ch.ready);
    @(negedge clk);
  endtask

  // long segments carry only their first, one middle and their final byte
  task automatic send_segment(input logic [SEQ_W-1:0] start, input int unsigned len,
                              input bit complete);
    int unsigned off;
    int unsigned stop;
    stop = complete ? len : len - 1;
    if (len <= 8) begin
      for (off = 0; off < stop; off++)
        send(MODE_DATA, start, OFF_W'(off), BYTE_W'($urandom), off == len - 1);
    end else begin
      send(MODE_DATA, start, '0, BYTE_W'($urandom), 1'b0);
      send(MODE_DATA, start, OFF_W'($urandom_range(1, len - 2)), BYTE_W'($urandom), 1'b0);
      if (complete) send(MODE_DATA, start, OFF_W'(len - 1), BYTE_W'($urandom), 1'b1);
    end
  endtask

  task automatic drain(input int unsigned busy_pct);
    while (draining_now) begin
      if ($urandom_range(99) < busy_pct)
        send(MODE_DATA, $urandom, OFF_W'($urandom_range(0, SEGMENT_BYTES - 1)),
             BYTE_W'($urandom), 1'($urandom));
      else
        send(MODE_TICK, $urandom, '0, '0, 1'b0);
    end
  endtask

  task automatic run_round();
    logic [SEQ_W-1:0] starts [5];
    int unsigned      lens [4];
    int unsigned      order [4];
    int unsigned      nseg;
    int unsigned      style;
    int unsigned      tmp;
    int unsigned      noise;
    int               i;
    int               j;
    logic [1:0]       mode;
    nseg      = $urandom_range(1, 4);
    starts[0] = next_expected;
    for (i = 0; i < nseg; i++) begin
      lens[i]     = ($urandom_range(99) < 2) ? $urandom_range(9, SEGMENT_BYTES)
                                             : $urandom_range(1, 6);
      starts[i+1] = starts[i] + lens[i];
      order[i]    = i;
    end
    style = $urandom_range(2);
    if (style == 1) begin
      for (i = 0; i < nseg; i++) order[i] = nseg - 1 - i;
    end else if (style == 2) begin
      for (i = nseg - 1; i > 0; i--) begin
        j        = $urandom_range(0, i);
        tmp      = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
    end
    if ($urandom_range(99) < 20 && starts[0] != 0)
      send_segment($urandom_range(0, starts[0] - 1), $urandom_range(1, 6), 1'b1);
    for (i = 0; i < nseg; i++) begin
      send_segment(starts[order[i]], lens[order[i]], $urandom_range(99) >= 4);
      if ($urandom_range(99) >= 5) drain(10);
    end
    if ($urandom_range(99) < 15) begin
      noise = $urandom_range(1, 3);
      repeat (noise) begin
        mode = 2'($urandom_range(2));
        if (mode == MODE_FIN) mode = MODE_UNUSED;
        send(mode, $urandom, OFF_W'($urandom), BYTE_W'($urandom), 1'($urandom));
      end
    end
    drain(10);
  endtask

  initial begin
    logic [SEQ_W-1:0] base;
    int unsigned      p;
    rst                = 1'b1;
    seg_ch.valid       = 1'b0;
    seg_ch.mode        = MODE_DATA;
    seg_ch.seg_seq     = '0;
    seg_ch.byte_offset = '0;
    seg_ch.data_byte   = '0;
    seg_ch.last_byte   = 1'b0;
    phase         = 0;
    counted_items = 0;
    hold_go       = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // ignored: idle tick, unused mode, offsets past the segment size
    send(MODE_TICK, '0, '0, '0, 1'b0);
    send(MODE_UNUSED, '1, '1, '1, 1'b1);
    send(MODE_DATA, '0, OFF_W'(SEGMENT_BYTES), 8'h11, 1'b1);
    send(MODE_DATA, '0, '1, 8'h22, 1'b0);
    // byte of an unclassified segment
    send(MODE_DATA, 32'd7, 11'd5, 8'h33, 1'b1);
    // ahead, then in-order that starts a drain, busy, drain to ack
    send(MODE_DATA, 32'd2, 11'd0, 8'hA2, 1'b0);
    send(MODE_DATA, 32'd2, 11'd1, 8'hA3, 1'b1);
    send(MODE_DATA, 32'd0, 11'd0, 8'h00, 1'b0);
    send(MODE_DATA, 32'd0, 11'd1, 8'hFF, 1'b1);
    send(MODE_DATA, 32'd0, 11'd0, 8'h44, 1'b0);
    send(MODE_TICK, '0, '0, '0, 1'b0);
    send(MODE_TICK, '0, '0, '0, 1'b0);
    // duplicate, single-byte in-order, ahead across the top of the space
    send(MODE_DATA, 32'd0, 11'd0, 8'h55, 1'b1);
    send(MODE_DATA, 32'd4, 11'd0, 8'h66, 1'b1);
    send(MODE_DATA, '1, 11'd0, 8'h77, 1'b0);
    send(MODE_DATA, '1, 11'd1, 8'h88, 1'b1);
    // largest offset
    send(MODE_DATA, 32'd5, 11'd0, 8'h99, 1'b0);
    send(MODE_DATA, 32'd5, OFF_W'(SEGMENT_BYTES - 1), 8'hAA, 1'b1);

    hold_go <= 1'b1;
    for (p = 0; p < 4; p++) begin
      phase <= p;
      counted_items = 0;
      while (counted_items < PHASE_ITEMS) run_round();
    end

    // fin while draining, then items after close
    drain(0);
    base = next_expected;
    send_segment(base + 32'd2, 2, 1'b1);
    send_segment(base, 2, 1'b1);
    send(MODE_FIN, '0, '0, '0, 1'b0);
    send(MODE_DATA, next_expected, '0, 8'h5A, 1'b1);
    send(MODE_TICK, '0, '0, '0, 1'b0);
    send(MODE_FIN, '0, '0, '0, 1'b0);
    seg_ch.valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
